FILE: rtl/core/lbm_pkg.sv
// Package: shared types and helper functions for the layer blend block.
`default_nettype none
package lbm_pkg;

  localparam int unsigned ChW   = 8;
  localparam int unsigned ModeW = 4;

  // Blend mode codes
  localparam logic [ModeW-1:0] ModeDarken    = 4'd0;
  localparam logic [ModeW-1:0] ModeMultiply  = 4'd1;
  localparam logic [ModeW-1:0] ModeBurn      = 4'd2;
  localparam logic [ModeW-1:0] ModeLinBurn   = 4'd3;
  localparam logic [ModeW-1:0] ModeLighten   = 4'd4;
  localparam logic [ModeW-1:0] ModeScreen    = 4'd5;
  localparam logic [ModeW-1:0] ModeDodge     = 4'd6;
  localparam logic [ModeW-1:0] ModeLinDodge  = 4'd7;
  localparam logic [ModeW-1:0] ModeOverlay   = 4'd8;
  localparam logic [ModeW-1:0] ModeSoftLight = 4'd9;
  localparam logic [ModeW-1:0] ModeHardLight = 4'd10;
  localparam logic [ModeW-1:0] ModeVivid     = 4'd11;
  localparam logic [ModeW-1:0] ModeLinLight  = 4'd12;
  localparam logic [ModeW-1:0] ModePinLight  = 4'd13;
  localparam logic [ModeW-1:0] ModeDiff      = 4'd14;
  localparam logic [ModeW-1:0] ModeExclusion = 4'd15;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } lbm_ctrl_t;

  function automatic logic [ChW-1:0] lin_burn(input logic [ChW-1:0] a, input logic [ChW-1:0] b);
    logic [ChW:0] s;
    s = {1'b0, a} + {1'b0, b};
    lin_burn = (s < 9'd255) ? 8'd0 : ChW'(s - 9'd255);
  endfunction

  function automatic logic [ChW-1:0] lin_dodge(input logic [ChW-1:0] a, input logic [ChW-1:0] b);
    logic [ChW:0] s;
    s = {1'b0, a} + {1'b0, b};
    lin_dodge = s[ChW] ? 8'd255 : s[ChW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/layer_blend_modes_rgb8_top.sv
// Top level: three-channel 8-bit layer blend with 16 selectable modes.
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+------------------------
//  input    | in_valid_i / in_ready_o, base_*, layer_*  | target + blend pixel
//  output   | out_valid_o / out_ready_i, mixed_ch0..2   | blended pixel
//  config   | cfg_we_i, cfg_wdata_i                     | blend mode register
//
// One pixel per clock sustained while out_ready_i is held high. Four register
// stages: operand capture, 8x8 multiply plus upper divider bits, divide-by-255
// plus lower divider bits, mode select into the output register. rst_ni clears
// the valid bits and the mode register. A stall on the output holds the output
// stage and each occupied stage directly behind it; stages behind a gap move on.
`default_nettype none
module layer_blend_modes_rgb8_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lbm_pkg::ModeW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lbm_pkg::ChW-1:0]   base_ch0_i,
  input  logic [lbm_pkg::ChW-1:0]   base_ch1_i,
  input  logic [lbm_pkg::ChW-1:0]   base_ch2_i,
  input  logic [lbm_pkg::ChW-1:0]   layer_ch0_i,
  input  logic [lbm_pkg::ChW-1:0]   layer_ch1_i,
  input  logic [lbm_pkg::ChW-1:0]   layer_ch2_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lbm_pkg::ChW-1:0]   mixed_ch0_o,
  output logic [lbm_pkg::ChW-1:0]   mixed_ch1_o,
  output logic [lbm_pkg::ChW-1:0]   mixed_ch2_o
);
  import lbm_pkg::*;

  logic [ModeW-1:0] mode_q, mode_d;
  lbm_ctrl_t        ctrl;

  // mode register; only written while the pipeline is idle (a rule for the user, not enforced by the block)
  assign mode_d = cfg_we_i ? cfg_wdata_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeDarken;
    end else begin
      mode_q <= mode_d;
    end
  end

  lbm_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  // one identical datapath per color channel
  lbm_chan u_ch0 (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .mode_i (mode_q),
    .a_i    (base_ch0_i),
    .b_i    (layer_ch0_i),
    .y_o    (mixed_ch0_o)
  );

  lbm_chan u_ch1 (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .mode_i (mode_q),
    .a_i    (base_ch1_i),
    .b_i    (layer_ch1_i),
    .y_o    (mixed_ch1_o)
  );

  lbm_chan u_ch2 (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .mode_i (mode_q),
    .a_i    (base_ch2_i),
    .b_i    (layer_ch2_i),
    .y_o    (mixed_ch2_o)
  );
endmodule
`default_nettype wire

FILE: rtl/core/lbm_pipe_ctrl.sv
// Pipeline control: valid bits and per-stage load enables for the four stages.
`default_nettype none
module lbm_pipe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lbm_pkg::lbm_ctrl_t ctrl_o
);
  import lbm_pkg::*;

  logic [3:0] v_q, v_d;
  logic       rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v_q[3] || out_ready_i;
  assign rdy3 = !v_q[2] || rdy4;
  assign rdy2 = !v_q[1] || rdy3;
  assign rdy1 = !v_q[0] || rdy2;

  always_comb begin
    v_d = v_q;
    if (rdy1) v_d[0] = in_valid_i;
    if (rdy2) v_d[1] = v_q[0];
    if (rdy3) v_d[2] = v_q[1];
    if (rdy4) v_d[3] = v_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign ctrl_o      = '{en1: rdy1, en2: rdy2, en3: rdy3, en4: rdy4};
  assign in_ready_o  = rdy1;
  assign out_valid_o = v_q[3];
endmodule
`default_nettype wire

FILE: rtl/core/lbm_chan.sv
// One channel datapath: multiply, divide-by-255, burn/dodge divider, mode select.
`default_nettype none
module lbm_chan (
  input  logic                      clk_i,
  input  lbm_pkg::lbm_ctrl_t        ctrl_i,
  input  logic [lbm_pkg::ModeW-1:0] mode_i,
  input  logic [lbm_pkg::ChW-1:0]   a_i,
  input  logic [lbm_pkg::ChW-1:0]   b_i,
  output logic [lbm_pkg::ChW-1:0]   y_o
);
  import lbm_pkg::*;

  // stage 1: operands
  logic [ChW-1:0]   a1_q, b1_q;
  logic [ModeW-1:0] m1_q;

  // stage 2
  logic [ChW-1:0]   a2_q, b2_q, d2_q, r2_q;
  logic [ModeW-1:0] m2_q;
  logic [15:0]      p2_q;
  logic             ovf2_q, dodge2_q;
  logic [3:0]       qh2_q;

  // stage 3
  logic [ChW-1:0]   a3_q, b3_q, ph3_q, qd3_q;
  logic [ModeW-1:0] m3_q;
  logic [ChW:0]     q255_3_q;
  logic             ovf3_q, dodge3_q;

  logic [ChW-1:0]   y_q;

  // ---- stage A: multiplier and divider upper bits
  logic           is_dodge, inv, is_mul_b7;
  logic [ChW-1:0] h, x0, xm, ym, beff, d, nhi, ra;
  logic [ChW:0]   r9a;
  logic [3:0]     qa;
  logic           ovf;

  always_comb begin
    h         = {1'b0, a1_q[ChW-1:1]} + 8'd64;
    is_mul_b7 = (m1_q == ModeOverlay || m1_q == ModeSoftLight) && b1_q[ChW-1];
    inv       = (m1_q == ModeScreen) || is_mul_b7 ||
                ((m1_q == ModeHardLight) && a1_q[ChW-1]);
    x0        = (m1_q == ModeSoftLight) ? h : a1_q;
    xm        = inv ? ~x0 : x0;
    ym        = inv ? ~b1_q : b1_q;

    is_dodge  = (m1_q == ModeDodge) || ((m1_q == ModeVivid) && b1_q[ChW-1]);
    if (m1_q == ModeVivid) beff = {b1_q[ChW-2:0], 1'b0};
    else                   beff = b1_q;
    d   = is_dodge ? ~beff : beff;
    nhi = is_dodge ? a1_q : ~a1_q;
    // zero divisor lands here too: burn gives 0, dodge 255
    ovf = (nhi >= d);
    ra  = nhi;
    qa  = '0;
    for (int i = 3; i >= 0; i--) begin
      r9a = {ra, 1'b0};
      if (r9a >= {1'b0, d}) begin
        r9a   = r9a - {1'b0, d};
        qa[i] = 1'b1;
      end
      ra = r9a[ChW-1:0];
    end
  end

  // ---- stage B: scale, divide by 255, divider lower bits
  logic        dbl;
  logic [7:0]  addc;
  logic [16:0] n;
  logic [17:0] t, qq, rr;
  logic [ChW:0] q255;
  logic [ChW-1:0] rb;
  logic [ChW:0]   r9b;
  logic [3:0]     qb;

  always_comb begin
    dbl = (m2_q == ModeOverlay) || (m2_q == ModeSoftLight) ||
          (m2_q == ModeHardLight) || (m2_q == ModeExclusion);
    if (m2_q == ModeMultiply) addc = 8'd127;
    else if (m2_q == ModeSoftLight && b2_q[ChW-1]) addc = 8'd254;  // ceiling
    else addc = 8'd0;
    n  = (dbl ? {p2_q, 1'b0} : {1'b0, p2_q}) + {9'd0, addc};
    t  = {1'b0, n} + {9'd0, n[16:8]};
    qq = {8'd0, t[17:8]};
    rr = {1'b0, n} - (({qq[9:0], 8'd0}) - qq);
    q255 = (rr >= 18'd255) ? (ChW+1)'(1) + qq[ChW:0] : qq[ChW:0];

    rb = r2_q;
    qb = '0;
    for (int i = 3; i >= 0; i--) begin
      r9b = {rb, 1'b0};
      if (r9b >= {1'b0, d2_q}) begin
        r9b   = r9b - {1'b0, d2_q};
        qb[i] = 1'b1;
      end
      rb = r9b[ChW-1:0];
    end
  end

  // ---- stage C: per-mode select
  logic [ChW-1:0] q8, bb, y_d, divres;
  logic [ChW:0]   ex;

  always_comb begin
    q8 = q255_3_q[ChW-1:0];
    bb = {b3_q[ChW-2:0], 1'b0};
    ex = {1'b0, a3_q} + {1'b0, b3_q} - q255_3_q;
    if (dodge3_q) divres = ovf3_q ? 8'd255 : qd3_q;
    else          divres = (ovf3_q || qd3_q == 8'd255) ? 8'd0 : ~qd3_q;
    unique case (m3_q)
      ModeDarken:    y_d = (a3_q < b3_q) ? a3_q : b3_q;
      ModeMultiply:  y_d = q8;
      ModeBurn,
      ModeDodge,
      ModeVivid:     y_d = divres;
      ModeLinBurn:   y_d = lin_burn(a3_q, b3_q);
      ModeLighten:   y_d = (a3_q > b3_q) ? a3_q : b3_q;
      ModeScreen:    y_d = ~ph3_q;
      ModeLinDodge:  y_d = lin_dodge(a3_q, b3_q);
      ModeOverlay,
      ModeSoftLight: y_d = b3_q[ChW-1] ? ~q8 : q8;
      ModeHardLight: y_d = a3_q[ChW-1] ? ~q8 : q8;
      ModeLinLight:  y_d = b3_q[ChW-1] ? lin_dodge(a3_q, bb) : lin_burn(a3_q, bb);
      ModePinLight: begin
        if (b3_q[ChW-1]) y_d = (a3_q > bb) ? a3_q : bb;
        else             y_d = (a3_q < bb) ? a3_q : bb;
      end
      ModeDiff:      y_d = (a3_q > b3_q) ? a3_q - b3_q : b3_q - a3_q;
      ModeExclusion: y_d = ex[ChW-1:0];
      default:       y_d = q8;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      a1_q <= a_i;
      b1_q <= b_i;
      m1_q <= mode_i;
    end
    if (ctrl_i.en2) begin
      a2_q     <= a1_q;
      b2_q     <= b1_q;
      m2_q     <= m1_q;
      p2_q     <= xm * ym;
      d2_q     <= d;
      r2_q     <= ra;
      qh2_q    <= qa;
      ovf2_q   <= ovf;
      dodge2_q <= is_dodge;
    end
    if (ctrl_i.en3) begin
      a3_q     <= a2_q;
      b3_q     <= b2_q;
      m3_q     <= m2_q;
      ph3_q    <= p2_q[15:8];
      q255_3_q <= q255;
      qd3_q    <= {qh2_q, qb};
      ovf3_q   <= ovf2_q;
      dodge3_q <= dodge2_q;
    end
    if (ctrl_i.en4) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;
endmodule
`default_nettype wire

FILE: rtl/core/lbm_checker.sv
// Port-level checker for the layer blend top level, with its bind.
`default_nettype none
module lbm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [lbm_pkg::ChW-1:0]   mixed_ch0_o,
  input logic [lbm_pkg::ChW-1:0]   mixed_ch1_o,
  input logic [lbm_pkg::ChW-1:0]   mixed_ch2_o
);
  logic acc;
  assign acc = in_valid_i && in_ready_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mixed_ch0_o) &&
      $stable(mixed_ch1_o) && $stable(mixed_ch2_o))
    else $error("output changed during stall");

  // a free output slot lets the input side move
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input blocked with free output");

  // quiet input cycles with an open sink drain the pipeline
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(acc, 1) && !$past(acc, 2) && !$past(acc, 3) && !$past(acc, 4) &&
     $past(out_ready_i, 1) && $past(out_ready_i, 2) && $past(out_ready_i, 3) &&
     $past(out_ready_i, 4)) |-> !out_valid_o)
    else $error("result appeared from nothing");

  // an accept followed by open-sink cycles through every stage shows a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("result late");
endmodule

bind layer_blend_modes_rgb8_top lbm_checker u_lbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .mixed_ch0_o (mixed_ch0_o),
  .mixed_ch1_o (mixed_ch1_o),
  .mixed_ch2_o (mixed_ch2_o)
);
`default_nettype wire

FILE: test/testbench.sv
// Testbench for the three-channel layer blend block: directed and random pixels per mode.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lbm_pkg::*;

  typedef logic [ChW-1:0] ch_t;

  typedef struct packed {
    ch_t c0;
    ch_t c1;
    ch_t c2;
  } rgb_t;

  // Scoreboard: holds the blended pixels still owed by the block.
  class blend_board;
    rgb_t owed_q[$];
    logic [ModeW-1:0] mode;
    int errors;
    int matched;

    function new();
      mode = ModeDarken;
      errors = 0;
      matched = 0;
    endfunction

    static function int burn(int a, int b);
      int q;
      if (b == 0) return 0;
      q = ((255 - a) * 256) / b;
      return (q >= 255) ? 0 : 255 - q;
    endfunction

    static function int dodge(int a, int b);
      int q;
      if (b >= 255) return 255;
      q = (a * 256) / (255 - b);
      return (q > 255) ? 255 : q;
    endfunction

    static function int ovl(int a, int b);
      if (b < 128) return 2 * a * b / 255;
      return 255 - 2 * (255 - a) * (255 - b) / 255;
    endfunction

    function ch_t mix_channel(ch_t base, ch_t layer);
      int a, b, h, n, r;
      a = base;
      b = layer;
      case (mode)
        ModeDarken:    r = (a < b) ? a : b;
        ModeMultiply:  r = (a * b + 127) / 255;
        ModeBurn:      r = burn(a, b);
        ModeLinBurn:   r = (a + b < 255) ? 0 : a + b - 255;
        ModeLighten:   r = (a > b) ? a : b;
        ModeScreen:    r = 255 - (((255 - a) * (255 - b)) >> 8);
        ModeDodge:     r = dodge(a, b);
        ModeLinDodge:  r = (a + b > 255) ? 255 : a + b;
        ModeOverlay:   r = ovl(a, b);
        ModeSoftLight: begin
          h = (a >> 1) + 64;
          if (b < 128) r = (2 * h * b) / 255;
          else begin
            n = 2 * (255 - h) * (255 - b);
            r = 255 - (n + 254) / 255;
          end
        end
        ModeHardLight: r = ovl(b, a);
        ModeVivid:     r = (b < 128) ? burn(a, 2 * b) : dodge(a, 2 * (b - 128));
        ModeLinLight: begin
          if (b < 128) r = (a + 2 * b < 255) ? 0 : a + 2 * b - 255;
          else r = (a + 2 * (b - 128) > 255) ? 255 : a + 2 * (b - 128);
        end
        ModePinLight: begin
          if (b < 128) r = (a < 2 * b) ? a : 2 * b;
          else r = (a > 2 * (b - 128)) ? a : 2 * (b - 128);
        end
        ModeDiff:      r = (a > b) ? a - b : b - a;
        default:       r = a + b - 2 * a * b / 255;
      endcase
      return ch_t'(r);
    endfunction

    function void note_pixel(rgb_t base, rgb_t layer);
      rgb_t m;
      m.c0 = mix_channel(base.c0, layer.c0);
      m.c1 = mix_channel(base.c1, layer.c1);
      m.c2 = mix_channel(base.c2, layer.c2);
      owed_q.push_back(m);
    endfunction

    function void check_pixel(rgb_t got);
      rgb_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected pixel %h", $time, got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.c0 !== want.c0) begin
        $display("%0t: ch0 expected %0d actual %0d", $time, want.c0, got.c0);
        errors++;
      end
      if (got.c1 !== want.c1) begin
        $display("%0t: ch1 expected %0d actual %0d", $time, want.c1, got.c1);
        errors++;
      end
      if (got.c2 !== want.c2) begin
        $display("%0t: ch2 expected %0d actual %0d", $time, want.c2, got.c2);
        errors++;
      end
      matched++;
    endfunction
  endclass

  localparam int Latency = 4;
  localparam int StallLimit = 5000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [ModeW-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  ch_t base_ch0_i, base_ch1_i, base_ch2_i;
  ch_t layer_ch0_i, layer_ch1_i, layer_ch2_i;
  logic out_valid_o;
  logic out_ready_i;
  ch_t mixed_ch0_o, mixed_ch1_o, mixed_ch2_o;

  layer_blend_modes_rgb8_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .base_ch0_i (base_ch0_i),
    .base_ch1_i (base_ch1_i),
    .base_ch2_i (base_ch2_i),
    .layer_ch0_i(layer_ch0_i),
    .layer_ch1_i(layer_ch1_i),
    .layer_ch2_i(layer_ch2_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .mixed_ch0_o(mixed_ch0_o),
    .mixed_ch1_o(mixed_ch1_o),
    .mixed_ch2_o(mixed_ch2_o)
  );

  blend_board board = new();

  // Idle percentages per side, changed between phases.
  int send_idle_pct;
  int recv_stall_pct;
  // Long receiver hold-off requested by the stimulus process.
  bit hold_request;
  int idle_cycles;
  int pixels_sent;
  bit run_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: ready toggles at the falling edge, transfers checked at the rising edge.
  initial begin
    int hold_left;
    out_ready_i = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request && hold_left == 0) begin
        hold_left = 200;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_pixel({mixed_ch0_o, mixed_ch1_o, mixed_ch2_o});
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (!run_done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // One pixel transfer; valid stays high with the payload until accepted.
  // Valid drops only on a sender gap, in set_mode or at the end of the run.
  task automatic send_pixel(rgb_t base, rgb_t layer);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    {base_ch0_i, base_ch1_i, base_ch2_i} <= base;
    {layer_ch0_i, layer_ch1_i, layer_ch2_i} <= layer;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_pixel(base, layer);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // Mode writes only with the pipeline drained.
  task automatic set_mode(logic [ModeW-1:0] m);
    in_valid_i <= 1'b0;
    while (board.owed_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 2) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.mode = m;
  endtask

  // Channel values biased toward the ends and the 127/128 split.
  function automatic ch_t pick_ch();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return ch_t'($urandom_range(126, 129));
      default: return ch_t'($urandom);
    endcase
  endfunction

  function automatic rgb_t pick_rgb();
    return {pick_ch(), pick_ch(), pick_ch()};
  endfunction

  initial begin
    rgb_t edge_vals [0:5];
    int phase;
    run_done = 1'b0;
    hold_request = 1'b0;
    pixels_sent = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = ModeDarken;
    in_valid_i = 1'b0;
    {base_ch0_i, base_ch1_i, base_ch2_i} = '0;
    {layer_ch0_i, layer_ch1_i, layer_ch2_i} = '0;
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset mode first, then each mode against the field extremes,
    // the 127/128 split and the zero-divisor burn / full-scale dodge cases.
    edge_vals[0] = {8'd0, 8'd255, 8'd128};
    edge_vals[1] = {8'd255, 8'd0, 8'd127};
    edge_vals[2] = {8'd0, 8'd0, 8'd64};
    edge_vals[3] = {8'd255, 8'd255, 8'd1};
    edge_vals[4] = {8'd170, 8'd85, 8'd129};
    edge_vals[5] = {8'd1, 8'd254, 8'd126};
    for (int i = 0; i < 6; i++) send_pixel(edge_vals[i], edge_vals[5 - i]);
    for (int m = 0; m < 16; m++) begin
      set_mode(m[ModeW-1:0]);
      send_pixel(edge_vals[m % 6], edge_vals[(m + 1) % 6]);
    end

    // Random phases cycle through the idle patterns; mode changes per block,
    // ending on the extreme codes.
    for (int blk = 0; blk < 36; blk++) begin
      phase = blk % 4;
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 84 : 29) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 84 : 29) : 0;
      if (blk == 34) set_mode(ModeDarken);
      else if (blk == 35) set_mode(ModeExclusion);
      else set_mode(ModeW'($urandom_range(15)));
      if (blk == 4) hold_request = 1'b1;
      repeat (50) send_pixel(pick_rgb(), pick_rgb());
    end

    in_valid_i <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (board.owed_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    run_done = 1'b1;
    $display("Sent %0d pixels over all 16 modes, %0d results checked,", pixels_sent,
             board.matched);
    $display("with sender gaps, receiver stalls and a long output hold-off.");
    if (board.errors == 0 && board.owed_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
